[rtl/core/utf16le_to_utf8_transcoder_unit_macros.svh]
// ---------------------------------------------------------------------------
// utf16le_to_utf8_transcoder_unit assertion macros
// shared concurrent assertion forms for the transcoder modules
// ---------------------------------------------------------------------------
`ifndef UTF16LE_TO_UTF8_TRANSCODER_UNIT_MACROS_SVH
`define UTF16LE_TO_UTF8_TRANSCODER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define U16U8_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define U16U8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/u16u8_pkg.sv]
// ---------------------------------------------------------------------------
// u16u8_pkg
// types, constants and the code point encoder of the utf-16le to utf-8 unit
// ---------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

    localparam int GROUP_MAX = 6;
    localparam int CNT_W     = 3;

    localparam logic [15:0] BOM_UNIT       = 16'hFEFF;
    localparam logic [15:0] SURR_HIGH_LO   = 16'hD800;
    localparam logic [15:0] SURR_HIGH_HI   = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_LO    = 16'hDC00;
    localparam logic [15:0] SURR_LOW_HI    = 16'hDFFF;
    localparam logic [20:0] PLANE1_BASE    = 21'h10000;
    localparam logic [20:0] MAX_ONE_BYTE   = 21'h00007F;
    localparam logic [20:0] MAX_TWO_BYTE   = 21'h0007FF;
    localparam logic [20:0] MAX_THREE_BYTE = 21'h00FFFF;
    localparam logic [7:0]  LEAD2          = 8'hC0;
    localparam logic [7:0]  LEAD3          = 8'hE0;
    localparam logic [7:0]  LEAD4          = 8'hF0;
    localparam logic [7:0]  CONT           = 8'h80;

    // transcoder state
    typedef struct packed {
        logic       odd_phase;
        logic [7:0] held_low_byte;
        logic       surrogate_pending;
        logic [9:0] pending_high_bits;
        logic       at_first_unit;
    } u16u8_state_t;

    localparam u16u8_state_t STATE_RESET = '{
        odd_phase:         1'b0,
        held_low_byte:     8'h00,
        surrogate_pending: 1'b0,
        pending_high_bits: 10'h000,
        at_first_unit:     1'b1
    };

    // all bytes caused by one input byte, first byte in slot 0
    typedef struct packed {
        logic [GROUP_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } u16u8_group_t;

    // utf-8 encoding of one code point
    typedef struct packed {
        logic [3:0][7:0]  b;
        logic [CNT_W-1:0] len;
    } u16u8_enc_t;

    function automatic u16u8_enc_t encode_cp(input logic [20:0] cp);
        u16u8_enc_t e;
        e = '0;
        if (cp <= MAX_ONE_BYTE)
        begin
            e.b[0] = cp[7:0];
            e.len  = 3'd1;
        end
        else if (cp <= MAX_TWO_BYTE)
        begin
            e.b[0] = LEAD2 | {3'b000, cp[10:6]};
            e.b[1] = CONT | {2'b00, cp[5:0]};
            e.len  = 3'd2;
        end
        else if (cp <= MAX_THREE_BYTE)
        begin
            e.b[0] = LEAD3 | {4'b0000, cp[15:12]};
            e.b[1] = CONT | {2'b00, cp[11:6]};
            e.b[2] = CONT | {2'b00, cp[5:0]};
            e.len  = 3'd3;
        end
        else
        begin
            e.b[0] = LEAD4 | {5'b00000, cp[20:18]};
            e.b[1] = CONT | {2'b00, cp[17:12]};
            e.b[2] = CONT | {2'b00, cp[11:6]};
            e.b[3] = CONT | {2'b00, cp[5:0]};
            e.len  = 3'd4;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

[rtl/core/u16u8_decode.sv]
// ---------------------------------------------------------------------------
// u16u8_decode
// pairs bytes into code units, tracks surrogates, forms the output byte group
// ---------------------------------------------------------------------------
`default_nettype none

module u16u8_decode (
    input  wire logic                   [7:0] in_byte,
    input  wire logic                         stream_first,
    input  wire logic                         stream_last,
    input  wire u16u8_pkg::u16u8_state_t      state,
    output u16u8_pkg::u16u8_state_t           state_next,
    output u16u8_pkg::u16u8_group_t           group
);

    u16u8_pkg::u16u8_state_t st;
    u16u8_pkg::u16u8_enc_t   enc;
    u16u8_pkg::u16u8_enc_t   flush_enc;
    logic [15:0]             unit;
    logic                    is_low;
    logic                    is_high;
    logic                    flush_a;
    logic                    have_b;
    logic [20:0]             cp_b;

    // unit handling and state update
    always_comb
    begin
        st         = stream_first ? u16u8_pkg::STATE_RESET : state;
        state_next = st;
        unit       = {in_byte, st.held_low_byte};
        is_low     = (unit >= u16u8_pkg::SURR_LOW_LO) && (unit <= u16u8_pkg::SURR_LOW_HI);
        is_high    = (unit >= u16u8_pkg::SURR_HIGH_LO) && (unit <= u16u8_pkg::SURR_HIGH_HI);
        flush_a    = 1'b0;
        have_b     = 1'b0;
        cp_b       = '0;
        if (!st.odd_phase)
        begin
            state_next.odd_phase     = 1'b1;
            state_next.held_low_byte = in_byte;
        end
        else
        begin
            state_next.odd_phase     = 1'b0;
            state_next.held_low_byte = 8'h00;
            state_next.at_first_unit = 1'b0;
            // a leading byte-order mark is dropped
            if (!(st.at_first_unit && (unit == u16u8_pkg::BOM_UNIT)))
            begin
                if (st.surrogate_pending && is_low)
                begin
                    cp_b = u16u8_pkg::PLANE1_BASE
                           + {1'b0, st.pending_high_bits, unit[9:0]};
                    have_b = 1'b1;
                    state_next.surrogate_pending = 1'b0;
                    state_next.pending_high_bits = '0;
                end
                else
                begin
                    flush_a = st.surrogate_pending;
                    state_next.surrogate_pending = 1'b0;
                    state_next.pending_high_bits = '0;
                    if (is_high)
                    begin
                        state_next.surrogate_pending = 1'b1;
                        state_next.pending_high_bits = unit[9:0];
                    end
                    else
                    begin
                        cp_b   = {5'b00000, unit};
                        have_b = 1'b1;
                    end
                end
            end
        end
        // end of stream: flush a held surrogate, drop an odd byte
        if (stream_last)
        begin
            if (!st.odd_phase)
            begin
                flush_a = st.surrogate_pending;
            end
            else if (state_next.surrogate_pending)
            begin
                cp_b = {5'b00000, u16u8_pkg::SURR_HIGH_LO
                                  | {6'b000000, state_next.pending_high_bits}};
                have_b = 1'b1;
            end
            state_next = u16u8_pkg::STATE_RESET;
        end
    end

    assign enc       = u16u8_pkg::encode_cp(cp_b);
    assign flush_enc = u16u8_pkg::encode_cp({5'b00000, u16u8_pkg::SURR_HIGH_LO
                                             | {6'b000000, st.pending_high_bits}});

    // byte group assembly: old surrogate flush first, then the new encoding
    always_comb
    begin
        group.bytes = '0;
        if (flush_a)
        begin
            group.bytes[0] = flush_enc.b[0];
            group.bytes[1] = flush_enc.b[1];
            group.bytes[2] = flush_enc.b[2];
            group.bytes[3] = enc.b[0];
            group.bytes[4] = enc.b[1];
            group.bytes[5] = enc.b[2];
        end
        else
        begin
            group.bytes[0] = enc.b[0];
            group.bytes[1] = enc.b[1];
            group.bytes[2] = enc.b[2];
            group.bytes[3] = enc.b[3];
        end
        group.count = (flush_a ? 3'd3 : 3'd0) + (have_b ? enc.len : 3'd0);
    end

endmodule

`default_nettype wire

[rtl/core/u16u8_emit.sv]
// ---------------------------------------------------------------------------
// u16u8_emit
// result register: holds one byte group and sends it one byte per request
// ---------------------------------------------------------------------------
`default_nettype none

`include "utf16le_to_utf8_transcoder_unit_macros.svh"

module u16u8_emit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire u16u8_pkg::u16u8_group_t      load_group,
    output logic                              load_ready,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic                        [7:0] m_axis_tdata,  // utf8_byte
    output logic                              m_axis_tlast   // run_last
);

    u16u8_pkg::u16u8_group_t         group_reg;
    logic                            valid_reg;
    logic [u16u8_pkg::CNT_W-1:0]     idx_reg;
    logic                            take;
    logic                            last_byte;

    assign last_byte     = (idx_reg == (group_reg.count - 3'd1));
    assign take          = valid_reg && m_axis_tready;
    assign load_ready    = !valid_reg || (take && last_byte);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = group_reg.bytes[idx_reg];
    assign m_axis_tlast  = last_byte;

    // group payload
    always_ff @(posedge clk)
    begin
        if (load && load_ready)
        begin
            group_reg <= load_group;
        end
    end

    // byte sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load && load_ready)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                valid_reg <= 1'b0;
                idx_reg   <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    `U16U8_ASSERT_NOW(a_load_nonempty, clk, rst_n, load, load_group.count != 3'd0, "empty group loaded")
    `U16U8_ASSERT_NOW(a_idx_in_group, clk, rst_n, valid_reg, idx_reg < group_reg.count, "byte index past group end")
    `U16U8_ASSERT_NEXT(a_more_follow, clk, rst_n, take && !last_byte, valid_reg, "group cut short")

endmodule

`default_nettype wire

[rtl/core/utf16le_to_utf8_transcoder_unit.sv]
// ---------------------------------------------------------------------------
// utf16le_to_utf8_transcoder_unit
// converts a utf-16le byte stream into a utf-8 byte stream
// ---------------------------------------------------------------------------
// usage
//   slave channel takes one raw byte per request: tdata = in_byte, tuser marks
//   the first byte of a stream, tlast the final byte of a stream
//   master channel sends one utf-8 byte per request: tdata = utf8_byte, tlast
//   set on the last byte caused by one input byte
//   an accepted byte is held in the input register; its byte group is formed
//   and loaded into the result register once that register is free, which
//   then presents the first output byte
//   the result register sends one byte per cycle while the receiver is ready;
//   an input byte that yields n output bytes (0 to 6) keeps the result
//   register busy while the next byte waits in the input register; bytes
//   that yield nothing pass at one per cycle, so typical text is paced by
//   the one-byte output port
//   a stalled receiver holds the result register, then the input register,
//   then deasserts s_axis_tready; nothing is lost or repeated
//   reset empties both registers and returns the transcoder to stream start
// ---------------------------------------------------------------------------
`default_nettype none

`include "utf16le_to_utf8_transcoder_unit_macros.svh"

module utf16le_to_utf8_transcoder_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // in_byte
    input  wire logic       s_axis_tuser,   // stream_first
    input  wire logic       s_axis_tlast,   // stream_last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata,   // utf8_byte
    output logic            m_axis_tlast    // run_last
);

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    first_reg;
    logic                    last_reg;
    u16u8_pkg::u16u8_state_t state_reg;
    u16u8_pkg::u16u8_state_t state_next;
    u16u8_pkg::u16u8_group_t group;
    logic                    emit_ready;
    logic                    consume;
    logic                    load;

    assign load          = in_valid_reg && (group.count != 3'd0) && emit_ready;
    assign consume       = in_valid_reg && ((group.count == 3'd0) || emit_ready);
    assign s_axis_tready = !in_valid_reg || consume;

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            first_reg   <= s_axis_tuser;
            last_reg    <= s_axis_tlast;
        end
    end

    // input register valid and transcoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= u16u8_pkg::STATE_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (consume)
            begin
                state_reg <= state_next;
            end
        end
    end

    u16u8_decode u_decode (
        .in_byte      (in_byte_reg),
        .stream_first (first_reg),
        .stream_last  (last_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .group        (group)
    );

    u16u8_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .load_group    (group),
        .load_ready    (emit_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    `U16U8_ASSERT_NEXT(a_end_resets, clk, rst_n, consume && last_reg, state_reg == u16u8_pkg::STATE_RESET, "state not cleared after stream end")
    `U16U8_ASSERT_NOW(a_first_no_pending, clk, rst_n, state_reg.at_first_unit, !state_reg.surrogate_pending, "surrogate held before first unit")
    `U16U8_ASSERT_NEXT(a_item_held, clk, rst_n, in_valid_reg && !consume, in_valid_reg && $stable(in_byte_reg), "input item lost while stalled")

endmodule

`default_nettype wire
